@@ rtl/core/dwsc_pkg.sv @@
package dwsc_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 48;
    localparam int RUN_W = 7;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      first;
    } in_beat_t;

    typedef struct packed {
        logic [RUN_W-1:0]   run_length;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } out_beat_t;

    // window result handed from the cell chain to the accumulator
    typedef struct packed {
        logic             first;
        logic             trunc;
        logic [CNT_W-1:0] len;
    } win_info_t;

    // low bits of the window length, as the run_length field carries them
    function automatic logic [RUN_W-1:0] to_run_length(input logic [CNT_W-1:0] len);
        logic [CNT_W+RUN_W-1:0] ext;
        ext = {{RUN_W{1'b0}}, len};
        return ext[RUN_W-1:0];
    endfunction

endpackage

@@ rtl/core/dwsc_cell.sv @@
module dwsc_cell import dwsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  logic [VALUE_W-1:0] key,
    input  logic [VALUE_W-1:0] data_in,
    input  logic               valid_in,
    output logic [VALUE_W-1:0] data_out,
    output logic               hit
);

    logic [VALUE_W-1:0] value_reg;
    logic               valid_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= valid_in;
        end
    end

    assign data_out = value_reg;
    assign hit      = valid_reg && (value_reg == key);

endmodule

@@ rtl/core/dwsc_chain.sv @@
module dwsc_chain import dwsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      shift_en,
    input  in_beat_t  beat,
    output win_info_t info
);

    logic [VALUE_W-1:0]      key;
    logic [VALUE_W-1:0]      link [WINDOW_DEPTH+1];
    logic [WINDOW_DEPTH-1:0] hit;
    logic [WINDOW_DEPTH-1:0] hit_eff;
    logic [WINDOW_DEPTH-1:0] valid_next;
    logic [IDX_W-1:0]        match_idx;
    logic                    match;
    logic [CNT_W-1:0]        cnt_eff;
    logic                    full;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    win_info_t               info_reg;
    win_info_t               info_next;

    assign key     = beat.value;
    assign link[0] = key;

    // newest entry sits in cell 0, older ones move one cell down per beat
    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        assign valid_next[k] = CNT_W'(k) < count_next;

        dwsc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .key      (key),
            .data_in  (link[k]),
            .valid_in (valid_next[k]),
            .data_out (link[k+1]),
            .hit      (hit[k])
        );
    end

    // a start beat sees an empty window
    assign hit_eff = beat.first ? '0 : hit;
    assign cnt_eff = beat.first ? '0 : count_reg;
    assign match   = |hit_eff;
    assign full    = (cnt_eff == FULL_COUNT);

    // entries are distinct, so at most one cell hits
    always_comb begin
        match_idx = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            match_idx = match_idx | (hit_eff[k] ? IDX_W'(k) : '0);
        end
    end

    always_comb begin
        if (match) begin
            count_next = CNT_W'(match_idx) + CNT_W'(1);
        end else if (full) begin
            count_next = FULL_COUNT;
        end else begin
            count_next = cnt_eff + CNT_W'(1);
        end
    end

    always_comb begin
        info_next.first = beat.first;
        info_next.trunc = !match && full;
        info_next.len   = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (shift_en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

@@ rtl/core/dwsc_accum.sv @@
module dwsc_accum import dwsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      in_valid,
    input  win_info_t info,
    output logic      out_valid,
    output out_beat_t out_beat
);

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    out_beat_t          out_reg;
    logic [TOTAL_W-1:0] base;
    logic [TOTAL_W:0]   sum;
    logic               sat;

    assign base = info.first ? '0 : total_reg;
    assign sum  = {1'b0, base} + (TOTAL_W+1)'(info.len);
    // carry out means the sum passed the top of the range
    assign sat  = sum[TOTAL_W];

    assign total_next = sat ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign ovf_next   = (info.first ? 1'b0 : ovf_reg) | info.trunc | sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid;
            if (in_valid) begin
                total_reg <= total_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            out_reg.run_length <= to_run_length(info.len);
            out_reg.total      <= total_next;
            out_reg.overflow   <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

@@ rtl/core/distinct_window_subarray_counter_core.sv @@
// the window result is registered in the chain and the total in the accumulator
// throughput: one beat per cycle unless m_ready holds it; the cell chain compares
// every window entry at once and the 48-bit saturating add is in the stage after it
// the whole two-stage pipeline holds while a result waits on m_ready
// reset (aresetn low, synchronous) empties the window and clears total and overflow
module distinct_window_subarray_counter_core import dwsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      advance;
    logic      accept;
    logic      p_valid_reg;
    win_info_t info;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (advance) begin
            p_valid_reg <= s_valid;
        end
    end

    dwsc_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .beat     (s_data),
        .info     (info)
    );

    dwsc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (p_valid_reg),
        .info      (info),
        .out_valid (m_valid),
        .out_beat  (m_data)
    );

endmodule

@@ rtl/core/dwsc_checker.sv @@
module dwsc_checker import dwsc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    logic [TOTAL_W-1:0] run_ext;

    assign run_ext = TOTAL_W'(m_data.run_length);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting input beat holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input beat changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // input side never stalls while the output register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // every result counts at least its own window
    a_total_covers_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.run_length != '0 && m_data.total >= run_ext)
        else $error("total below run length");

endmodule

bind distinct_window_subarray_counter_core dwsc_checker u_dwsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
